>>> rtl/rtp_pkg.sv
// rtp_pkg: shared widths, constants, prescaler codes and the pipeline
// stage struct for the rpm_to_timer_period block. No dependencies.
package rtp_pkg;

  localparam int RPM_W  = 16;
  localparam int RATE_W = 13;
  localparam int DIV_W  = 25;   // width of the tick clock constant
  localparam int PER_W  = 16;
  localparam int CODE_W = 2;

  localparam logic [RPM_W-1:0]  RPM_MIN    = 16'd10;
  localparam logic [RPM_W-1:0]  RPM_MAX    = 16'd10000;
  localparam logic [RATE_W-1:0] RATE_CAP   = 13'd5000;
  localparam logic [DIV_W-1:0]  TICK_CLOCK = 25'd29491200;

  localparam logic [CODE_W-1:0] PS_DIV1   = 2'd0;
  localparam logic [CODE_W-1:0] PS_DIV8   = 2'd1;
  localparam logic [CODE_W-1:0] PS_DIV64  = 2'd2;
  localparam logic [CODE_W-1:0] PS_DIV256 = 2'd3;

  // One slot of the divider chain.
  typedef struct packed {
    logic              valid;
    logic              oor;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] rem;
    logic [DIV_W-1:0]  quo;
  } stage_t;

endpackage

>>> rtl/rtp_div_cell.sv
// rtp_div_cell: one restoring-division step of the divider chain.
// Depends on rtp_pkg (stage_t, widths).
module rtp_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            dbit_i,
  input  rtp_pkg::stage_t stage_i,
  output rtp_pkg::stage_t stage_o
);

  logic [rtp_pkg::RATE_W:0]   trial;
  logic [rtp_pkg::RATE_W:0]   diff;
  logic                       fits;
  rtp_pkg::stage_t            stage_d;
  rtp_pkg::stage_t            stage_q;
  logic                       valid_q;

  // Bring down the next dividend bit, subtract when the divisor fits.
  always_comb begin
    trial   = {stage_i.rem, dbit_i};
    fits    = (trial >= {1'b0, stage_i.rate});
    diff    = trial - {1'b0, stage_i.rate};
    stage_d = stage_i;
    stage_d.rem = fits ? diff[rtp_pkg::RATE_W-1:0] : trial[rtp_pkg::RATE_W-1:0];
    stage_d.quo = {stage_i.quo[rtp_pkg::DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

>>> rtl/rtp_prescale.sv
// rtp_prescale: turns the quotient into ticks, picks the prescaler and
// holds the result register. Depends on rtp_pkg.
module rtp_prescale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  rtp_pkg::stage_t            stage_i,
  output logic                       valid_o,
  output logic                       out_of_range_o,
  output logic [rtp_pkg::CODE_W-1:0] prescale_code_o,
  output logic [rtp_pkg::PER_W-1:0]  period_count_o,
  output logic [rtp_pkg::RATE_W-1:0] sample_hz_o
);

  logic [rtp_pkg::DIV_W-1:0]  ticks;
  logic [rtp_pkg::CODE_W-1:0] code_d, code_q;
  logic [rtp_pkg::PER_W-1:0]  period_d, period_q;
  logic [rtp_pkg::RATE_W-1:0] hz_d, hz_q;
  logic                       oor_q;
  logic                       valid_q;

  always_comb begin
    ticks = stage_i.quo - {{(rtp_pkg::DIV_W-1){1'b0}}, 1'b1};
    priority if (ticks[rtp_pkg::DIV_W-1:16] == '0) begin
      code_d   = rtp_pkg::PS_DIV1;
      period_d = ticks[15:0];
    end else if (ticks[rtp_pkg::DIV_W-1:19] == '0) begin
      code_d   = rtp_pkg::PS_DIV8;
      period_d = ticks[18:3];
    end else if (ticks[rtp_pkg::DIV_W-1:22] == '0) begin
      code_d   = rtp_pkg::PS_DIV64;
      period_d = ticks[21:6];
    end else begin
      code_d   = rtp_pkg::PS_DIV256;
      period_d = ticks[23:8];
    end
    hz_d = stage_i.rate;
    // Drop the code, period and rate fields to zero for a rejected speed.
    if (stage_i.oor) begin
      code_d   = rtp_pkg::PS_DIV1;
      period_d = '0;
      hz_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oor_q    <= stage_i.oor;
      code_q   <= code_d;
      period_q <= period_d;
      hz_q     <= hz_d;
    end
  end

  assign valid_o         = valid_q;
  assign out_of_range_o  = oor_q;
  assign prescale_code_o = code_q;
  assign period_count_o  = period_q;
  assign sample_hz_o     = hz_q;

endmodule

>>> rtl/rpm_to_timer_period.sv
// rpm_to_timer_period: motor speed to sampling timer setup, top level.
// A result passes the division cells, then the result register, to the output.
// Throughput: one request per cycle unless the output stalls; a chain of 25
// division cells, one quotient bit each, plus the result register, in lockstep.
// Reset (rst_ni low, asynchronous) empties the chain and the output register.
// Depends on rtp_pkg, rtp_div_cell and rtp_prescale.
module rpm_to_timer_period (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [rtp_pkg::RPM_W-1:0]  rpm_i,
  // result channel
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic                       out_of_range_o,
  output logic [rtp_pkg::CODE_W-1:0] prescale_code_o,
  output logic [rtp_pkg::PER_W-1:0]  period_count_o,
  output logic [rtp_pkg::RATE_W-1:0] sample_hz_o
);

  // The chain advances as one; it only holds when a finished result sits
  // in the output register and the consumer stalls it. Empty slots keep
  // moving, so a request enters every cycle the output is free or taken.
  logic            advance;
  logic [rtp_pkg::RPM_W-2:0] half_rpm;
  logic [rtp_pkg::RATE_W-1:0] rate;
  logic            oor;
  rtp_pkg::stage_t chain [0:rtp_pkg::DIV_W];

  assign advance = !(valid_o && stall_i);
  assign stall_o = !advance;

  // Range check and rate: floor(rpm/2), capped at the rate limit. A zero
  // rate cannot pass the range check, but is rejected all the same.
  always_comb begin
    half_rpm = rpm_i[rtp_pkg::RPM_W-1:1];
    if (half_rpm > {2'b00, rtp_pkg::RATE_CAP}) begin
      rate = rtp_pkg::RATE_CAP;
    end else begin
      rate = half_rpm[rtp_pkg::RATE_W-1:0];
    end
    oor = (rpm_i < rtp_pkg::RPM_MIN) || (rpm_i > rtp_pkg::RPM_MAX) || (rate == '0);
  end

  // Head of the chain: partial remainder and quotient start at zero.
  assign chain[0] = '{valid: valid_i, oor: oor, rate: rate, rem: '0, quo: '0};

  // One cell per quotient bit, fed the tick clock constant MSB first.
  for (genvar k = 0; k < rtp_pkg::DIV_W; k++) begin : g_cell
    rtp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .dbit_i  (rtp_pkg::TICK_CLOCK[rtp_pkg::DIV_W-1-k]),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  // Ticks = quotient - 1, prescaler pick, result register.
  rtp_prescale u_prescale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .stage_i         (chain[rtp_pkg::DIV_W]),
    .valid_o         (valid_o),
    .out_of_range_o  (out_of_range_o),
    .prescale_code_o (prescale_code_o),
    .period_count_o  (period_count_o),
    .sample_hz_o     (sample_hz_o)
  );

endmodule

>>> rtl/rtp_chk.sv
// rtp_chk: port-level checks for rpm_to_timer_period, bound to the top.
// Depends on rtp_pkg for widths.
module rtp_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_i,
  input logic                       stall_o,
  input logic [rtp_pkg::RPM_W-1:0]  rpm_i,
  input logic                       valid_o,
  input logic                       stall_i,
  input logic                       out_of_range_o,
  input logic [rtp_pkg::CODE_W-1:0] prescale_code_o,
  input logic [rtp_pkg::PER_W-1:0]  period_count_o,
  input logic [rtp_pkg::RATE_W-1:0] sample_hz_o
);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(period_count_o) && $stable(sample_hz_o))
    else $error("stalled result changed");

  // Stall the request side only while an output result is stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("request stalled without output backpressure");

  // A rejected speed carries zero fields.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_of_range_o |->
      prescale_code_o == rtp_pkg::PS_DIV1 && period_count_o == '0 && sample_hz_o == '0)
    else $error("out-of-range result with nonzero fields");

  // An accepted speed gives a rate between 5 Hz and the cap.
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_of_range_o |->
      sample_hz_o >= 13'd5 && sample_hz_o <= rtp_pkg::RATE_CAP)
    else $error("sample rate out of bounds");

endmodule

bind rpm_to_timer_period rtp_chk u_rtp_chk (.*);
